FILE: rtl/nlr_pkg.sv
package nlr_pkg;

    // width of a length field on the result side
    localparam int LEN_W = 6;

    // character codes
    localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
    localparam logic [7:0] CH_SEVEN   = 8'h37; // '7'
    localparam logic [7:0] CH_NINE    = 8'h39; // '9'
    localparam logic [7:0] CH_DOT     = 8'h2E; // '.'
    localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
    localparam logic [7:0] CH_MINUS   = 8'h2D; // '-'
    localparam logic [7:0] CH_X_LO    = 8'h78; // 'x'
    localparam logic [7:0] CH_X_UP    = 8'h58; // 'X'
    localparam logic [7:0] CH_E_LO    = 8'h65; // 'e'
    localparam logic [7:0] CH_E_UP    = 8'h45; // 'E'
    localparam logic [7:0] CH_F_LO    = 8'h66; // 'f'
    localparam logic [7:0] CH_F_UP    = 8'h46; // 'F'
    localparam logic [7:0] CH_A_LO    = 8'h61; // 'a'
    localparam logic [7:0] CH_A_UP    = 8'h41; // 'A'

    // character classes, all clear on end of input
    typedef struct packed {
        logic zero;
        logic dig;
        logic oct;
        logic hex;
        logic dot;
        logic ee;
        logic xx;
        logic ff;
        logic sg;
    } char_class_t;

    // one result transaction
    typedef struct packed {
        logic [LEN_W-1:0] integer_length;
        logic [LEN_W-1:0] floating_length;
        logic             overflow;
    } result_t;

endpackage

FILE: rtl/nlr_char_class.sv
module nlr_char_class (
    input  logic [7:0]           char_code,
    input  logic                 text_end,
    output nlr_pkg::char_class_t cls
);
    import nlr_pkg::*;

    logic live;

    // decode the byte into the classes both recognizers use
    always_comb
    begin
        live      = !text_end;
        cls.zero  = live && (char_code == CH_ZERO);
        cls.dig   = live && (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        cls.oct   = live && (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
        cls.hex   = cls.dig
                    || (live && (char_code >= CH_A_LO) && (char_code <= CH_F_LO))
                    || (live && (char_code >= CH_A_UP) && (char_code <= CH_F_UP));
        cls.dot   = live && (char_code == CH_DOT);
        cls.ee    = live && ((char_code == CH_E_LO) || (char_code == CH_E_UP));
        cls.xx    = live && ((char_code == CH_X_LO) || (char_code == CH_X_UP));
        cls.ff    = live && ((char_code == CH_F_LO) || (char_code == CH_F_UP));
        cls.sg    = live && ((char_code == CH_PLUS) || (char_code == CH_MINUS));
    end

endmodule

FILE: rtl/nlr_lexer_core.sv
module nlr_lexer_core #(
    parameter int MAX_TOKEN = 63
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 eoi,
    input  nlr_pkg::char_class_t cls,
    output logic                 emit,
    output nlr_pkg::result_t     result
);
    import nlr_pkg::*;

    localparam int POS_W   = $clog2(MAX_TOKEN + 1);
    localparam int HOLD_W  = $clog2(MAX_TOKEN + 2);
    localparam int SAT_W   = (HOLD_W > LEN_W) ? HOLD_W : LEN_W;
    localparam int LEN_CAP = (MAX_TOKEN < 63) ? MAX_TOKEN : 63;

    typedef enum logic [2:0] {
        IP_START, IP_ZERO, IP_OCT, IP_HEX0, IP_HEX, IP_DEC
    } int_phase_t;

    typedef enum logic [2:0] {
        FP_START, FP_INT, FP_DOT0, FP_FRAC, FP_EXP0, FP_EXPS, FP_EXPD
    } flt_phase_t;

    int_phase_t         ip_reg, ip_next;
    flt_phase_t         fp_reg, fp_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [HOLD_W-1:0]  ihold_reg, ihold_next;
    logic [HOLD_W-1:0]  fhold_reg, fhold_next;
    logic               idec_reg, idec_next;
    logic               fdec_reg, fdec_next;
    logic               ovf_reg, ovf_next;

    logic               int_close, int_take_pos;
    logic               flt_close, included;
    logic [HOLD_W-1:0]  flt_len;
    logic [HOLD_W-1:0]  pos_ext;
    logic               both, taken;
    logic [SAT_W-1:0]   il_w, fl_w;

    assign pos_ext = HOLD_W'(pos_reg);

    // integer recognizer
    always_comb
    begin
        ip_next      = ip_reg;
        ihold_next   = ihold_reg;
        idec_next    = idec_reg;
        int_close    = 1'b0;
        int_take_pos = 1'b0;
        if (!idec_reg)
        begin
            unique case (ip_reg)
                IP_START:
                begin
                    if (cls.zero)     ip_next = IP_ZERO;
                    else if (cls.dig) ip_next = IP_DEC;
                    else              int_close = 1'b1;
                end
                IP_ZERO:
                begin
                    if (cls.xx)                  ip_next = IP_HEX0;
                    else if (cls.oct)            ip_next = IP_OCT;
                    else if (cls.dot || cls.ee)  int_close = 1'b1;
                    else
                    begin
                        int_close    = 1'b1;
                        int_take_pos = 1'b1;
                    end
                end
                IP_OCT:
                begin
                    if (!cls.oct)
                    begin
                        int_close    = 1'b1;
                        int_take_pos = !(cls.dot || cls.ee);
                    end
                end
                IP_HEX0:
                begin
                    if (cls.hex) ip_next = IP_HEX;
                    else         int_close = 1'b1;
                end
                IP_HEX:
                begin
                    if (!cls.hex)
                    begin
                        int_close    = 1'b1;
                        int_take_pos = 1'b1;
                    end
                end
                IP_DEC:
                begin
                    if (!cls.dig)
                    begin
                        int_close    = 1'b1;
                        int_take_pos = !(cls.dot || cls.ee);
                    end
                end
                default: int_close = 1'b1;
            endcase
            if (int_close)
            begin
                ihold_next = int_take_pos ? pos_ext : '0;
                idec_next  = 1'b1;
            end
        end
    end

    // floating recognizer
    always_comb
    begin
        fp_next    = fp_reg;
        fhold_next = fhold_reg;
        fdec_next  = fdec_reg;
        flt_close  = 1'b0;
        flt_len    = '0;
        included   = 1'b0;
        if (!fdec_reg)
        begin
            unique case (fp_reg) inside
                FP_START:
                begin
                    if (cls.dig)      fp_next = FP_INT;
                    else if (cls.dot) fp_next = FP_DOT0;
                    else              flt_close = 1'b1;
                end
                FP_INT:
                begin
                    if (cls.dig)
                    begin
                    end
                    else if (cls.dot) fp_next = FP_FRAC;
                    else if (cls.ee)
                    begin
                        fp_next    = FP_EXP0;
                        fhold_next = '0;
                    end
                    else flt_close = 1'b1;
                end
                FP_DOT0:
                begin
                    if (cls.dig) fp_next = FP_FRAC;
                    else         flt_close = 1'b1;
                end
                FP_FRAC, FP_EXPD:
                begin
                    if (cls.dig)
                    begin
                    end
                    else if (cls.ee && (fp_reg == FP_FRAC))
                    begin
                        fp_next    = FP_EXP0;
                        fhold_next = pos_ext;
                    end
                    else if (cls.ff)
                    begin
                        flt_close = 1'b1;
                        flt_len   = pos_ext + 1'b1;
                        included  = 1'b1;
                    end
                    else
                    begin
                        flt_close = 1'b1;
                        flt_len   = pos_ext;
                    end
                end
                FP_EXP0:
                begin
                    if (cls.sg)       fp_next = FP_EXPS;
                    else if (cls.dig) fp_next = FP_EXPD;
                    else
                    begin
                        // incomplete exponent falls back to the match before it
                        flt_close = 1'b1;
                        flt_len   = fhold_reg;
                    end
                end
                FP_EXPS:
                begin
                    if (cls.dig) fp_next = FP_EXPD;
                    else
                    begin
                        flt_close = 1'b1;
                        flt_len   = fhold_reg;
                    end
                end
                default: flt_close = 1'b1;
            endcase
            if (flt_close)
            begin
                fhold_next = flt_len;
                fdec_next  = 1'b1;
            end
        end
    end

    // position count and overflow, result formatting
    always_comb
    begin
        both     = idec_next && fdec_next;
        taken    = !eoi && (!both || included);
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        if (taken)
        begin
            if (pos_reg == POS_W'(MAX_TOKEN)) ovf_next = 1'b1;
            else                              pos_next = pos_reg + 1'b1;
        end
        il_w = SAT_W'(ihold_next);
        fl_w = SAT_W'(fhold_next);
        result.overflow = ovf_next || (il_w > SAT_W'(LEN_CAP)) || (fl_w > SAT_W'(LEN_CAP));
        if (il_w > SAT_W'(LEN_CAP)) il_w = SAT_W'(LEN_CAP);
        if (fl_w > SAT_W'(LEN_CAP)) fl_w = SAT_W'(LEN_CAP);
        result.integer_length  = il_w[LEN_W-1:0];
        result.floating_length = fl_w[LEN_W-1:0];
        emit = both;
    end

    // token state, cleared once a result goes out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg    <= IP_START;
            fp_reg    <= FP_START;
            pos_reg   <= '0;
            ihold_reg <= '0;
            fhold_reg <= '0;
            idec_reg  <= 1'b0;
            fdec_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (both)
            begin
                ip_reg    <= IP_START;
                fp_reg    <= FP_START;
                pos_reg   <= '0;
                ihold_reg <= '0;
                fhold_reg <= '0;
                idec_reg  <= 1'b0;
                fdec_reg  <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                ip_reg    <= ip_next;
                fp_reg    <= fp_next;
                pos_reg   <= pos_next;
                ihold_reg <= ihold_next;
                fhold_reg <= fhold_next;
                idec_reg  <= idec_next;
                fdec_reg  <= fdec_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

FILE: rtl/numeric_literal_recognizer.sv
// Numeric literal recognizer: feed the characters of one candidate token,
// first character first, on the char channel, or an end-of-input transaction.
// An integer and a floating recognizer run side by side; once both have
// decided, one result transaction gives both match lengths (0 for no match)
// and the next character starts a new token. An end-of-input transaction
// always closes the token. Lengths saturate at the smaller of MAX_TOKEN and
// 63, with overflow set. One character is taken per cycle while the result
// side keeps up: a transaction passes an input register, then the
// recognizer step and the result register; a stalled result holds the
// input stage.
module numeric_literal_recognizer #(
    parameter int MAX_TOKEN = 63
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        char_valid,
    output logic                        char_ready,
    input  logic [7:0]                  char_code,
    input  logic                        text_end,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [nlr_pkg::LEN_W-1:0]   integer_length,
    output logic [nlr_pkg::LEN_W-1:0]   floating_length,
    output logic                        overflow
);
    import nlr_pkg::*;

    localparam int LEN_CAP = (MAX_TOKEN < 63) ? MAX_TOKEN : 63;

    logic          char_valid_reg, char_valid_next;
    logic [7:0]    char_reg;
    logic          eoi_reg;
    logic          result_valid_reg, result_valid_next;
    result_t       result_reg;
    char_class_t   cls;
    result_t       core_result;
    logic          core_emit;
    logic          step_fire;

    // the held character steps when the result register can take its outcome
    assign step_fire  = char_valid_reg && (!result_valid_reg || result_ready);
    assign char_ready = !char_valid_reg || step_fire;

    nlr_char_class u_class (
        .char_code (char_reg),
        .text_end  (eoi_reg),
        .cls       (cls)
    );

    nlr_lexer_core #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_fire),
        .eoi    (eoi_reg),
        .cls    (cls),
        .emit   (core_emit),
        .result (core_result)
    );

    // valid bits of both stages
    always_comb
    begin
        char_valid_next = char_valid_reg;
        if (char_valid && char_ready) char_valid_next = 1'b1;
        else if (step_fire)           char_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (step_fire && core_emit) result_valid_next = 1'b1;
        else if (result_ready)      result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            char_valid_reg   <= char_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            char_reg <= char_code;
            eoi_reg  <= text_end;
        end
        if (step_fire && core_emit)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid    = result_valid_reg;
    assign integer_length  = result_reg.integer_length;
    assign floating_length = result_reg.floating_length;
    assign overflow        = result_reg.overflow;

    // end of input always closes the token
    a_eoi_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && eoi_reg) |=> result_valid)
        else $error("end-of-input transaction produced no result");

    // lengths never exceed the saturation cap
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((integer_length <= LEN_W'(LEN_CAP))
                          && (floating_length <= LEN_W'(LEN_CAP))))
        else $error("result length above saturation cap");

    // input stage only blocks behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid_reg && !char_ready) |-> (result_valid && !result_ready))
        else $error("input stage stalled without a stalled result");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import nlr_pkg::*;

    localparam int MAX_TOKEN   = 63;
    localparam int LEN_CAP     = (MAX_TOKEN < 63) ? MAX_TOKEN : 63;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    // recognizer phases
    typedef enum logic [3:0] {
        INT_START, INT_ZERO, INT_OCTAL, INT_HEX_PREFIX, INT_HEX, INT_DECIMAL
    } int_phase_t;

    typedef enum logic [3:0] {
        FLT_START, FLT_WHOLE, FLT_DOT_ONLY, FLT_FRACTION,
        FLT_EXP_MARK, FLT_EXP_SIGN, FLT_EXP_DIGITS
    } flt_phase_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                char_valid = 1'b0;
    logic                char_ready;
    logic [7:0]          char_code = 8'h00;
    logic                text_end = 1'b0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [LEN_W-1:0]    integer_length;
    logic [LEN_W-1:0]    floating_length;
    logic                overflow;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int chars_sent = 0;
    int error_count = 0;
    int cycle_count = 0;

    result_t pending_lengths[$];

    // token state of the predictor
    int_phase_t int_phase = INT_START;
    flt_phase_t flt_phase = FLT_START;
    int         tok_pos = 0;
    int         int_hold = 0;
    int         flt_hold = 0;
    bit         int_decided = 1'b0;
    bit         flt_decided = 1'b0;
    bit         tok_ovf = 1'b0;

    numeric_literal_recognizer #(
        .MAX_TOKEN(MAX_TOKEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_code(char_code),
        .text_end(text_end),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .integer_length(integer_length),
        .floating_length(floating_length),
        .overflow(overflow)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic int sat_len(input int v);
        return (v > LEN_CAP) ? LEN_CAP : v;
    endfunction

    // one character through both recognizers, returns 1 when a token closes
    function automatic bit recognize_char(input logic [7:0] c, input bit eoi,
                                          output result_t r);
        bit is_zero, is_dig, is_oct, is_hex, is_dot, is_exp, is_x, is_f, is_sign;
        bit grabbed;
        bit taken;
        int pos;
        int ilen;
        int flen;
        bit flt_done;
        is_zero = !eoi && c == CH_ZERO;
        is_dig  = !eoi && c >= CH_ZERO && c <= CH_NINE;
        is_oct  = !eoi && c >= CH_ZERO && c <= CH_SEVEN;
        is_hex  = is_dig || (!eoi && ((c >= CH_A_LO && c <= CH_F_LO) ||
                                      (c >= CH_A_UP && c <= CH_F_UP)));
        is_dot  = !eoi && c == CH_DOT;
        is_exp  = !eoi && (c == CH_E_LO || c == CH_E_UP);
        is_x    = !eoi && (c == CH_X_LO || c == CH_X_UP);
        is_f    = !eoi && (c == CH_F_LO || c == CH_F_UP);
        is_sign = !eoi && (c == CH_PLUS || c == CH_MINUS);
        pos = tok_pos;
        grabbed = 1'b0;
        r = '0;

        // integer recognizer, -1 while still open
        if (!int_decided)
        begin
            ilen = -1;
            case (int_phase)
                INT_START:
                    if (is_zero) int_phase = INT_ZERO;
                    else if (is_dig) int_phase = INT_DECIMAL;
                    else ilen = 0;
                INT_ZERO:
                    if (is_x) int_phase = INT_HEX_PREFIX;
                    else if (is_oct) int_phase = INT_OCTAL;
                    else if (is_dot || is_exp) ilen = 0;
                    else ilen = pos;
                INT_OCTAL:
                    if (!is_oct)
                    begin
                        if (is_dot || is_exp) ilen = 0;
                        else ilen = pos;
                    end
                INT_HEX_PREFIX:
                    if (is_hex) int_phase = INT_HEX;
                    else ilen = 0;
                INT_HEX:
                    if (!is_hex) ilen = pos;
                INT_DECIMAL:
                    if (!is_dig)
                    begin
                        if (is_dot || is_exp) ilen = 0;
                        else ilen = pos;
                    end
                default:
                    ilen = 0;
            endcase
            if (ilen >= 0)
            begin
                int_hold = ilen;
                int_decided = 1'b1;
            end
        end

        // floating recognizer, an incomplete exponent falls back to the hold
        if (!flt_decided)
        begin
            flt_done = 1'b0;
            flen = 0;
            case (flt_phase)
                FLT_START:
                    if (is_dig) flt_phase = FLT_WHOLE;
                    else if (is_dot) flt_phase = FLT_DOT_ONLY;
                    else flt_done = 1'b1;
                FLT_WHOLE:
                    if (!is_dig)
                    begin
                        if (is_dot) flt_phase = FLT_FRACTION;
                        else if (is_exp)
                        begin
                            flt_phase = FLT_EXP_MARK;
                            flt_hold = 0;
                        end
                        else flt_done = 1'b1;
                    end
                FLT_DOT_ONLY:
                    if (is_dig) flt_phase = FLT_FRACTION;
                    else flt_done = 1'b1;
                FLT_FRACTION:
                    if (!is_dig)
                    begin
                        if (is_exp)
                        begin
                            flt_phase = FLT_EXP_MARK;
                            flt_hold = pos;
                        end
                        else if (is_f)
                        begin
                            flt_done = 1'b1;
                            flen = pos + 1;
                            grabbed = 1'b1;
                        end
                        else
                        begin
                            flt_done = 1'b1;
                            flen = pos;
                        end
                    end
                FLT_EXP_MARK:
                    if (is_sign) flt_phase = FLT_EXP_SIGN;
                    else if (is_dig) flt_phase = FLT_EXP_DIGITS;
                    else
                    begin
                        flt_done = 1'b1;
                        flen = flt_hold;
                    end
                FLT_EXP_SIGN:
                    if (is_dig) flt_phase = FLT_EXP_DIGITS;
                    else
                    begin
                        flt_done = 1'b1;
                        flen = flt_hold;
                    end
                FLT_EXP_DIGITS:
                    if (!is_dig)
                    begin
                        flt_done = 1'b1;
                        flen = is_f ? pos + 1 : pos;
                        grabbed = is_f;
                    end
                default:
                    flt_done = 1'b1;
            endcase
            if (flt_done)
            begin
                flt_hold = flen;
                flt_decided = 1'b1;
            end
        end

        // character count, saturating at the token limit
        taken = !eoi && (!(int_decided && flt_decided) || grabbed);
        if (taken)
        begin
            if (tok_pos >= MAX_TOKEN) tok_ovf = 1'b1;
            else tok_pos++;
        end

        if (int_decided && flt_decided)
        begin
            r.integer_length  = LEN_W'(sat_len(int_hold));
            r.floating_length = LEN_W'(sat_len(flt_hold));
            r.overflow = tok_ovf || int_hold > LEN_CAP || flt_hold > LEN_CAP;
            int_phase = INT_START;
            flt_phase = FLT_START;
            tok_pos = 0;
            int_hold = 0;
            flt_hold = 0;
            int_decided = 1'b0;
            flt_decided = 1'b0;
            tok_ovf = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // predict on every accepted character transaction
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && char_valid && char_ready)
        begin
            if (recognize_char(char_code, text_end, r))
                pending_lengths.push_back(r);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // check every accepted result transaction against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_lengths.size() == 0)
                report_mismatch("unexpected result, integer_length",
                                int'(integer_length), 0);
            else
            begin
                want = pending_lengths.pop_front();
                if (integer_length !== want.integer_length)
                    report_mismatch("integer_length", int'(integer_length),
                                    int'(want.integer_length));
                if (floating_length !== want.floating_length)
                    report_mismatch("floating_length", int'(floating_length),
                                    int'(want.floating_length));
                if (overflow !== want.overflow)
                    report_mismatch("overflow", int'(overflow), int'(want.overflow));
            end
        end
    end

    // one character transaction, with a random gap in front
    task automatic send_char(input logic [7:0] c, input bit eoi);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        char_valid   <= 1'b1;
        char_code    <= eoi ? 8'($urandom_range(0, 255)) : c;
        text_end     <= eoi;
        do
            @(posedge clk);
        while (!char_ready);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
        if (close)
            send_char(8'h00, 1'b1);
    endtask

    // hold the sender until every predicted result is out
    task automatic wait_results_drained();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending_lengths.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        case ($urandom_range(0, 2))
            0: return CH_A_LO + 8'($urandom_range(0, 5));
            1: return CH_A_UP + 8'($urandom_range(0, 5));
            default: return rand_digit();
        endcase
    endfunction

    function automatic logic [7:0] rand_literal_char();
        case ($urandom_range(0, 9))
            4: return CH_DOT;
            5: return $urandom_range(0, 1) ? CH_E_LO : CH_E_UP;
            6: return $urandom_range(0, 1) ? CH_X_LO : CH_X_UP;
            7: return $urandom_range(0, 1) ? CH_F_LO : CH_F_UP;
            8: return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            9: return rand_hex_digit();
            default: return rand_digit();
        endcase
    endfunction

    // one candidate token, mostly well formed, then a random terminator
    task automatic send_random_token();
        int shape;
        int n;
        shape = $urandom_range(0, 99);
        n = $urandom_range(0, 4);
        if (shape < 4)
        begin
            // long run to reach saturation
            if ($urandom_range(0, 1)) send_char(CH_DOT, 1'b0);
            repeat ($urandom_range(56, 72)) send_char(rand_digit(), 1'b0);
        end
        else if (shape < 16)
        begin
            send_char(CH_ZERO + 8'($urandom_range(1, 9)), 1'b0);
            repeat (n) send_char(rand_digit(), 1'b0);
        end
        else if (shape < 26)
        begin
            send_char(CH_ZERO, 1'b0);
            repeat (n)
                send_char($urandom_range(0, 3) ? CH_ZERO + 8'($urandom_range(0, 7))
                                               : rand_digit(), 1'b0);
        end
        else if (shape < 38)
        begin
            send_char(CH_ZERO, 1'b0);
            send_char($urandom_range(0, 1) ? CH_X_LO : CH_X_UP, 1'b0);
            repeat (n) send_char(rand_hex_digit(), 1'b0);
        end
        else if (shape < 50)
        begin
            repeat ($urandom_range(1, 3)) send_char(rand_digit(), 1'b0);
            send_char(CH_DOT, 1'b0);
            repeat (n) send_char(rand_digit(), 1'b0);
        end
        else if (shape < 60)
        begin
            send_char(CH_DOT, 1'b0);
            repeat (n) send_char(rand_digit(), 1'b0);
        end
        else if (shape < 74)
        begin
            repeat ($urandom_range(1, 3)) send_char(rand_digit(), 1'b0);
            if ($urandom_range(0, 1))
            begin
                send_char(CH_DOT, 1'b0);
                repeat ($urandom_range(0, 2)) send_char(rand_digit(), 1'b0);
            end
            send_char($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, 1'b0);
            if ($urandom_range(0, 1))
                send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
            repeat ($urandom_range(0, 3)) send_char(rand_digit(), 1'b0);
        end
        else if (shape < 86)
        begin
            repeat ($urandom_range(1, 6)) send_char(rand_literal_char(), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
        end

        // optional float suffix
        if ($urandom_range(0, 9) < 3)
            send_char($urandom_range(0, 1) ? CH_F_LO : CH_F_UP, 1'b0);

        // terminator: end of input, random byte, space or straight into the next
        case ($urandom_range(0, 3))
            0: send_char(8'h00, 1'b1);
            1: send_char(8'($urandom_range(0, 255)), 1'b0);
            2: send_char(CH_SPACE, 1'b0);
            default: ;
        endcase
    endtask

    // short known tokens covering each class and corner
    task automatic test_directed();
        send_char(8'h00, 1'b1);     // end of input as first item
        send_text("09", 1'b1);      // leading zero then nine
        send_text("0xA", 1'b1);     // hex
        send_text("1.5e+3f", 1'b0); // full float with suffix
        send_text(".5", 1'b0);      // byte outside ascii terminates
        send_char(CH_HIGH, 1'b0);
        send_text("7e", 1'b1);      // incomplete exponent after bare digits
        send_text("0X", 1'b1);      // hex prefix without digits
    endtask

    // token longer than the limit, lengths saturate
    task automatic test_long_token();
        send_text("1.", 1'b0);
        repeat (64) send_char(rand_digit(), 1'b0);
        send_char(8'h00, 1'b1);
        send_text("0x", 1'b0);
        repeat (66) send_char(rand_hex_digit(), 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // random tokens under one idling setting, with a full drain midway
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_chars);
        int stop_at;
        int half_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = chars_sent + n_chars;
        half_at = chars_sent + n_chars / 2;
        while (chars_sent < half_at)
            send_random_token();
        send_char(8'h00, 1'b1);
        wait_results_drained();
        while (chars_sent < stop_at)
            send_random_token();
        send_char(8'h00, 1'b1);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 84;
        test_directed();
        test_long_token();
        test_random_traffic(29, 84, 100);
        test_random_traffic(84, 29, 100);
        test_random_traffic(0, 0, 100);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_lengths.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/nlr_pkg.sv
rtl/nlr_char_class.sv
rtl/nlr_lexer_core.sv
rtl/numeric_literal_recognizer.sv
dv/tb.sv
